@@ hdl/rcsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsfd_pkg: shared types and constants of the rc serial frame decoder
// System ids, status codes, result fields and the id lookup function.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

	// frame layout
	localparam logic [3:0] WORDS_PER_FRAME = 4'd7;
	localparam logic [6:0] CHANNEL_COUNT   = 7'd16;

	// system ids carried in the second header byte
	localparam logic [7:0] ID_DSM2_22 = 8'h01;
	localparam logic [7:0] ID_DSM2_11 = 8'h12;
	localparam logic [7:0] ID_DSMX_22 = 8'ha2;
	localparam logic [7:0] ID_DSMX_11 = 8'hb2;

	// system codes
	localparam logic [2:0] SYS_INVALID = 3'd0;
	localparam logic [2:0] SYS_DSM2_22 = 3'd1;
	localparam logic [2:0] SYS_DSM2_11 = 3'd2;
	localparam logic [2:0] SYS_DSMX_22 = 3'd3;
	localparam logic [2:0] SYS_DSMX_11 = 3'd4;

	// frame status codes
	localparam logic [1:0] FS_MORE  = 2'd0;
	localparam logic [1:0] FS_GOOD  = 2'd1;
	localparam logic [1:0] FS_ERROR = 2'd2;

	// configuration register indexes
	localparam logic CFG_AUX_MARGIN_WIDE   = 1'b0;
	localparam logic CFG_AUX_MARGIN_NARROW = 1'b1;

	// register reset values
	localparam logic [9:0] AUX_MARGIN_WIDE_RST   = 10'd111;
	localparam logic [8:0] AUX_MARGIN_NARROW_RST = 9'd56;

	// midpoints of the two value widths
	localparam logic [10:0] MID_NARROW = 11'd512;
	localparam logic [10:0] MID_WIDE   = 11'd1024;

	// aux channel range
	localparam logic [3:0] AUX_CH_LO = 4'd4;
	localparam logic [3:0] AUX_CH_HI = 4'd11;

	// one decoded word
	typedef struct packed {
		logic [3:0]         channel;
		logic [10:0]        raw_value;
		logic signed [10:0] centred_value;
		logic               aux_on;
		logic               word_ok;
		logic [2:0]         system_code;
	} rcsfd_word_t;

	// map a header system id to its system code
	function automatic logic [2:0] sys_from_id(input logic [7:0] id);
		logic [2:0] code;
		case (id)
			ID_DSM2_22: code = SYS_DSM2_22;
			ID_DSM2_11: code = SYS_DSM2_11;
			ID_DSMX_22: code = SYS_DSMX_22;
			ID_DSMX_11: code = SYS_DSMX_11;
			default:    code = SYS_INVALID;
		endcase
		return code;
	endfunction

endpackage

@@ hdl/rcsfd_word_dec.sv @@
// ----------------------------------------------------------------------------
// rcsfd_word_dec: payload word decoder
// Splits one big-endian payload word into channel and value by system width,
// centres the value and evaluates the aux threshold.
// ----------------------------------------------------------------------------
module rcsfd_word_dec (
	input  logic [15:0]             word,
	input  logic [2:0]              sys,
	input  logic [9:0]              aux_margin_wide,
	input  logic [8:0]              aux_margin_narrow,
	output rcsfd_pkg::rcsfd_word_t  dec
);
	import rcsfd_pkg::*;

	logic               narrow;
	logic [5:0]         chan_full;
	logic [10:0]        raw;
	logic [10:0]        cen;
	logic [9:0]         margin;
	logic               bad;
	logic               aux;

	// field split by value width
	always_comb begin
		narrow = (sys == SYS_DSM2_22);
		if (narrow) begin
			chan_full = word[15:10];
			raw       = {1'b0, word[9:0]};
			cen       = raw - MID_NARROW;
			margin    = {1'b0, aux_margin_narrow};
		end else begin
			chan_full = {2'b00, word[14:11]};
			raw       = word[10:0];
			cen       = raw - MID_WIDE;
			margin    = aux_margin_wide;
		end
	end

	// word check and aux threshold
	always_comb begin
		bad = (sys == SYS_INVALID) || ({1'b0, chan_full} >= CHANNEL_COUNT);
		aux = (chan_full[3:0] >= AUX_CH_LO) && (chan_full[3:0] <= AUX_CH_HI)
			&& ($signed({cen[10], cen}) >= $signed({2'b00, margin}));
	end

	// bad words report zeros
	always_comb begin
		dec.system_code = sys;
		dec.word_ok     = !bad;
		if (bad) begin
			dec.channel       = '0;
			dec.raw_value     = '0;
			dec.centred_value = '0;
			dec.aux_on        = 1'b0;
		end else begin
			dec.channel       = chan_full[3:0];
			dec.raw_value     = raw;
			dec.centred_value = $signed(cen);
			dec.aux_on        = aux;
		end
	end

endmodule

@@ hdl/rc_serial_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_unit: byte stream decoder for rc receiver frames
// Hunts header pairs, assembles payload words and emits one decoded word each, up to the first bad word.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while s_tready is high. A byte
// is held in an input register, decoded by short logic against the frame
// state, and the result lands in an output register. The input keeps flowing
// while a result waits, as long as the output register is free or being
// emptied in the same cycle; only a stalled result with a byte already
// waiting holds the input. Results come only on completed payload words, up
// to and including a frame's first bad word (status FS_ERROR): m_tlast marks
// the final word, m_tuser carries word_ok, frame status and system code.
module rc_serial_frame_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// byte input, tdata: rx_byte[7:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// word output, tdata: channel[3:0], raw_value[14:4], centred_value[25:15],
	// aux_on[26], zero fill[31:27]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// tuser: word_ok[0], frame_status[2:1], system_code[5:3]
	output logic [5:0]  m_tuser,
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data
);
	import rcsfd_pkg::*;

	logic [9:0]  aux_margin_wide_q;
	logic [8:0]  aux_margin_narrow_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;

	logic        in_payload_q;
	logic [7:0]  header_first_q;
	logic        header_half_q;
	logic [3:0]  payload_count_q;
	logic [7:0]  high_byte_q;
	logic [2:0]  protocol_q;
	logic        frame_error_q;

	logic [3:0]  count_next;
	logic        is_last;
	logic        emit;
	rcsfd_word_t dec;

	logic        out_valid_q;
	rcsfd_word_t out_word_q;
	logic [1:0]  out_status_q;
	logic        out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aux_margin_wide_q   <= AUX_MARGIN_WIDE_RST;
			aux_margin_narrow_q <= AUX_MARGIN_NARROW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AUX_MARGIN_WIDE:   aux_margin_wide_q   <= cfg_data;
				CFG_AUX_MARGIN_NARROW: aux_margin_narrow_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves when the output register is free or drains
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// word assembly and decode
	assign count_next = payload_count_q + 4'd1;
	assign is_last    = (count_next >= WORDS_PER_FRAME);
	assign emit       = step && in_payload_q && header_half_q && !frame_error_q;

	rcsfd_word_dec u_word_dec (
		.word              ({high_byte_q, byte_s1}),
		.sys               (protocol_q),
		.aux_margin_wide   (aux_margin_wide_q),
		.aux_margin_narrow (aux_margin_narrow_q),
		.dec               (dec)
	);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q    <= 1'b0;
			header_first_q  <= '0;
			header_half_q   <= 1'b0;
			payload_count_q <= '0;
			high_byte_q     <= '0;
			protocol_q      <= SYS_INVALID;
			frame_error_q   <= 1'b0;
		end else if (step) begin
			if (!in_payload_q) begin
				// header hunt, bytes in pairs
				if (!header_half_q) begin
					header_first_q <= byte_s1;
					header_half_q  <= 1'b1;
				end else begin
					header_half_q <= 1'b0;
					protocol_q    <= sys_from_id(byte_s1);
					if ((sys_from_id(byte_s1) != SYS_INVALID)
						&& (header_first_q[7:2] == 6'd0)) begin
						in_payload_q    <= 1'b1;
						payload_count_q <= '0;
						frame_error_q   <= 1'b0;
					end
				end
			end else if (!header_half_q) begin
				high_byte_q   <= byte_s1;
				header_half_q <= 1'b1;
			end else begin
				header_half_q <= 1'b0;
				if (is_last) begin
					in_payload_q    <= 1'b0;
					payload_count_q <= '0;
				end else begin
					payload_count_q <= count_next;
				end
				// a bad word ends decoding for this frame
				if (!frame_error_q && !dec.word_ok) begin
					protocol_q    <= SYS_INVALID;
					frame_error_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_word_q <= dec;
			out_last_q <= is_last;
			if (!dec.word_ok) begin
				out_status_q <= FS_ERROR;
			end else if (is_last) begin
				out_status_q <= FS_GOOD;
			end else begin
				out_status_q <= FS_MORE;
			end
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_word_q.aux_on, out_word_q.centred_value,
		out_word_q.raw_value, out_word_q.channel};
	assign m_tuser  = {out_word_q.system_code, out_status_q, out_word_q.word_ok};
	assign m_tlast  = out_last_q;

endmodule
